// ===== design/ptdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task due queue package
// Shared widths, mode codes, beat types and memory command types.
// ----------------------------------------------------------------------------
package ptdq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_SLOTS  = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int ID_W      = 4;
  localparam int PRIO_W    = 8;
  localparam int PERIOD_W  = 32;
  localparam int TICK_W    = 64;
  localparam int MODE_W    = 3;
  localparam int QCOUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CANNOT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INIT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SYSTEM   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MANUAL   = 3'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [TICK_W-1:0] tick_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    id_t                 task_id;
    prio_t               task_priority;
    logic [PERIOD_W-1:0] task_period;
    tick_t               now_tick;
  } request_t;

  typedef struct packed {
    logic                dispatched;
    id_t                 dispatched_id;
    logic                list_full_error;
    logic [QCOUNT_W-1:0] queued_count;
  } result_t;

  typedef struct packed {
    logic rd_en;
    idx_t rd_idx;
    logic wr_en;
    logic wr_front;
    idx_t wr_idx;
    id_t  wr_id;
    logic pop;
  } order_cmd_t;

  typedef struct packed {
    logic  rd_en;
    id_t   rd_id;
    id_t   wr_id;
    logic  wr_due_en;
    tick_t wr_due;
    logic  wr_prio_en;
    prio_t wr_prio;
  } task_cmd_t;

  typedef struct packed {
    tick_t due;
    prio_t prio;
  } task_data_t;

  function automatic idx_t idx_add(idx_t a, idx_t b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W + 1)'(MAX_TASKS)) begin
      sum = sum - (IDX_W + 1)'(MAX_TASKS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/ptdq_order_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Order list memory
// Circular list of task ids addressed relative to the head pointer.
// ----------------------------------------------------------------------------
module ptdq_order_list (
  input  wire                    clk,
  input  wire                    rst,
  input  ptdq_pkg::order_cmd_t   cmd,
  output ptdq_pkg::id_t          rd_id
);
  import ptdq_pkg::*;

  id_t  mem [MAX_TASKS];
  idx_t head;
  idx_t head_prev;
  idx_t wr_addr;
  idx_t rd_addr;

  assign head_prev = idx_add(head, idx_t'(MAX_TASKS - 1));
  assign wr_addr   = cmd.wr_front ? head_prev : idx_add(head, cmd.wr_idx);
  assign rd_addr   = idx_add(head, cmd.rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (cmd.pop) begin
      head <= idx_add(head, idx_t'(1));
    end else if (cmd.wr_en && cmd.wr_front) begin
      head <= head_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_id;
    end
    if (cmd.rd_en) begin
      rd_id <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/ptdq_task_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task table memory
// Due tick and priority for each task id, with separate field writes.
// ----------------------------------------------------------------------------
module ptdq_task_table (
  input  wire                    clk,
  input  ptdq_pkg::task_cmd_t    cmd,
  output ptdq_pkg::task_data_t   rd_data
);
  import ptdq_pkg::*;

  task_data_t mem [ID_SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.wr_due_en) begin
      mem[cmd.wr_id].due <= cmd.wr_due;
    end
    if (cmd.wr_prio_en) begin
      mem[cmd.wr_id].prio <= cmd.wr_prio;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_id];
    end
  end

endmodule
`default_nettype wire

// ===== design/ptdq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue sequencer
// Decodes each request, walks the order list and drives the result register.
// ----------------------------------------------------------------------------
module ptdq_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    request_valid,
  output logic                   request_stall,
  input  ptdq_pkg::request_t     request,
  output logic                   result_valid,
  input  wire                    result_stall,
  output ptdq_pkg::result_t      result,
  output ptdq_pkg::order_cmd_t   order_cmd,
  input  ptdq_pkg::id_t          order_id,
  output ptdq_pkg::task_cmd_t    task_cmd,
  input  ptdq_pkg::task_data_t   task_data
);
  import ptdq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_ORD,
    ST_D_CMP,
    ST_M_ADD,
    ST_INS,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_ROT,
    ST_RESULT
  } state_t;

  state_t   state;
  cnt_t     count;
  idx_t     idx;
  id_t      cur_id;
  id_t      carry;
  request_t r;
  tick_t    key;
  logic     res_disp;
  id_t      res_id;
  logic     res_err;

  logic  full;
  logic  goes_before;
  logic  last_entry;
  logic  at_tail;
  tick_t manual_due;

  assign full        = (count == CNT_W'(MAX_TASKS));
  assign goes_before = (task_data.due > key) ||
                       ((task_data.due == key) && (task_data.prio > r.task_priority));
  assign last_entry  = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign at_tail     = (CNT_W'(idx) == count);
  assign manual_due  = task_data.due + TICK_W'(r.task_period);
  assign request_stall = (state != ST_IDLE);

  always_comb begin
    order_cmd            = '0;
    task_cmd             = '0;
    task_cmd.wr_id       = r.task_id;
    order_cmd.wr_id      = r.task_id;
    unique case (state)
      ST_IDLE: begin
        if (request_valid) begin
          task_cmd.wr_id   = request.task_id;
          task_cmd.wr_due  = request.now_tick;
          task_cmd.wr_prio = request.task_priority;
          unique case (request.mode) inside
            MODE_DISPATCH: begin
              order_cmd.rd_en = 1'b1;
            end
            MODE_CANNOT: begin
              task_cmd.wr_prio_en = 1'b1;
              if (!full) begin
                order_cmd.wr_en    = 1'b1;
                order_cmd.wr_front = 1'b1;
                order_cmd.wr_id    = request.task_id;
              end
            end
            MODE_INIT: begin
              task_cmd.wr_due_en  = 1'b1;
              task_cmd.wr_prio_en = 1'b1;
            end
            MODE_SYSTEM: begin
              task_cmd.wr_prio_en = 1'b1;
            end
            MODE_MANUAL: begin
              task_cmd.wr_prio_en = 1'b1;
              task_cmd.rd_en      = 1'b1;
              task_cmd.rd_id      = request.task_id;
            end
            default: begin
            end
          endcase
        end
      end
      ST_D_ORD: begin
        task_cmd.rd_en = 1'b1;
        task_cmd.rd_id = order_id;
      end
      ST_D_CMP: begin
        order_cmd.pop = (r.now_tick >= task_data.due);
      end
      ST_M_ADD: begin
        task_cmd.wr_due_en = 1'b1;
        task_cmd.wr_due    = manual_due;
      end
      ST_INS: begin
        if (!full) begin
          if (count == '0) begin
            order_cmd.wr_en = 1'b1;
          end else begin
            order_cmd.rd_en = 1'b1;
          end
        end
      end
      ST_SCAN_A: begin
        task_cmd.rd_en   = 1'b1;
        task_cmd.rd_id   = order_id;
        order_cmd.rd_en  = 1'b1;
        order_cmd.rd_idx = idx + idx_t'(1);
      end
      ST_SCAN_B: begin
        if (goes_before) begin
          order_cmd.wr_en  = 1'b1;
          order_cmd.wr_idx = idx;
        end else if (last_entry) begin
          order_cmd.wr_en  = 1'b1;
          order_cmd.wr_idx = idx + idx_t'(1);
        end
      end
      ST_ROT: begin
        order_cmd.wr_en  = 1'b1;
        order_cmd.wr_idx = idx;
        order_cmd.wr_id  = carry;
        if (!at_tail) begin
          order_cmd.rd_en  = 1'b1;
          order_cmd.rd_idx = idx + idx_t'(1);
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_RESULT) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (request_valid) begin
            r        <= request;
            key      <= request.now_tick;
            res_disp <= 1'b0;
            res_id   <= '0;
            res_err  <= 1'b0;
            unique case (request.mode) inside
              MODE_DISPATCH: begin
                state <= (count == '0) ? ST_RESULT : ST_D_ORD;
              end
              MODE_CANNOT: begin
                if (full) begin
                  res_err <= 1'b1;
                end else begin
                  count <= count + CNT_W'(1);
                end
                state <= ST_RESULT;
              end
              MODE_INIT, MODE_SYSTEM: begin
                state <= ST_INS;
              end
              MODE_MANUAL: begin
                state <= ST_M_ADD;
              end
              default: begin
                state <= ST_RESULT;
              end
            endcase
          end
        end
        ST_D_ORD: begin
          cur_id <= order_id;
          state  <= ST_D_CMP;
        end
        ST_D_CMP: begin
          if (r.now_tick >= task_data.due) begin
            res_disp <= 1'b1;
            res_id   <= cur_id;
            count    <= count - CNT_W'(1);
          end
          state <= ST_RESULT;
        end
        ST_M_ADD: begin
          key   <= manual_due;
          state <= ST_INS;
        end
        ST_INS: begin
          if (full) begin
            res_err <= 1'b1;
            state   <= ST_RESULT;
          end else if (count == '0) begin
            count <= count + CNT_W'(1);
            state <= ST_RESULT;
          end else begin
            idx   <= '0;
            state <= ST_SCAN_A;
          end
        end
        ST_SCAN_A: begin
          cur_id <= order_id;
          state  <= ST_SCAN_B;
        end
        ST_SCAN_B: begin
          if (goes_before) begin
            carry <= cur_id;
            idx   <= idx + idx_t'(1);
            state <= ST_ROT;
          end else if (last_entry) begin
            count <= count + CNT_W'(1);
            state <= ST_RESULT;
          end else begin
            idx   <= idx + idx_t'(1);
            state <= ST_SCAN_A;
          end
        end
        ST_ROT: begin
          if (at_tail) begin
            count <= count + CNT_W'(1);
            state <= ST_RESULT;
          end else begin
            carry <= order_id;
            idx   <= idx + idx_t'(1);
          end
        end
        ST_RESULT: begin
          if (!result_valid || !result_stall) begin
            result.dispatched      <= res_disp;
            result.dispatched_id   <= res_id;
            result.list_full_error <= res_err;
            result.queued_count    <= QCOUNT_W'(count);
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/periodic_task_due_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task due queue
// Due-tick ordered task list with priority tie-break and FIFO on full ties.
// ----------------------------------------------------------------------------
// Requests arrive on the request channel and each one yields exactly one
// result beat on the result channel. A beat moves when valid is high and
// stall is low. The block works on one request at a time and stalls the
// request channel from the cycle after acceptance until its result has been
// loaded into the output register.
// A dispatch check reads the head id from the order list, then its task
// table entry, and compares the due tick; an empty list, a cannot-run push
// or an unknown mode goes straight to the result. A sorted insert compares
// list entries in order and moves each entry behind the new one back a slot;
// a manual yield first adds the period to the stored due tick. The scan is
// set by the order list memory read followed by the task table read per entry.
// The result register holds a finished result while the receiver stalls; the
// next request is accepted meanwhile, and its own result waits for the
// register to drain. Reset empties the list; the stored due ticks and
// priorities keep whatever they held and must be written before use.
// ----------------------------------------------------------------------------
module periodic_task_due_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 request_valid,
  output logic                request_stall,
  input  ptdq_pkg::request_t  request,
  output logic                result_valid,
  input  wire                 result_stall,
  output ptdq_pkg::result_t   result
);
  import ptdq_pkg::*;

  order_cmd_t order_cmd;
  id_t        order_id;
  task_cmd_t  task_cmd;
  task_data_t task_data;

  ptdq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .order_cmd     (order_cmd),
    .order_id      (order_id),
    .task_cmd      (task_cmd),
    .task_data     (task_data)
  );

  ptdq_order_list u_order_list (
    .clk   (clk),
    .rst   (rst),
    .cmd   (order_cmd),
    .rd_id (order_id)
  );

  ptdq_task_table u_task_table (
    .clk     (clk),
    .cmd     (task_cmd),
    .rd_data (task_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (request_valid && !request_stall) |=> request_stall)
    else $error("request accepted while a previous request was still in work");

  a_disp_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.dispatched && result.list_full_error))
    else $error("dispatch and list full error flagged in one beat");

  a_idle_id_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.dispatched) |-> (result.dispatched_id == '0))
    else $error("dispatched id nonzero without a dispatch");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.list_full_error) |->
      (result.queued_count == QCOUNT_W'(MAX_TASKS)))
    else $error("list full error reported with list not full");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_periodic_task_due_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task due queue testbench
// Sends scheduler requests with random gaps and receiver stalls, keeps a
// behavioral copy of the due-ordered task list, and checks every result beat
// field by field against it.
// ----------------------------------------------------------------------------
module tb_periodic_task_due_queue;
  import ptdq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam tick_t TICK_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  request_t request = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  periodic_task_due_queue dut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  id_t list_ids[$];
  tick_t due_of[ID_SLOTS];
  prio_t prio_of[ID_SLOTS];
  result_t expected_results[$];
  request_t beat_queue[$];
  bit due_written[ID_SLOTS];
  tick_t sim_now;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned calm_left = 0;
  bit calm = 1'b0;
  bit req_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  result_t want_res;

  int unsigned n_accepted = 0;
  int unsigned n_checks = 0;
  int unsigned n_inserts = 0;
  int unsigned n_spare = 0;
  int unsigned n_popped = 0;
  int unsigned n_rejected = 0;
  int unsigned deepest = 0;

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic result_t requeue_and_dispatch(request_t req);
    result_t res;
    int unsigned slot;
    tick_t key;
    res = '0;
    case (req.mode)
      MODE_DISPATCH: begin
        if (list_ids.size() > 0 && req.now_tick >= due_of[list_ids[0]]) begin
          res.dispatched = 1'b1;
          res.dispatched_id = list_ids.pop_front();
        end
      end
      MODE_CANNOT, MODE_INIT, MODE_SYSTEM, MODE_MANUAL: begin
        prio_of[req.task_id] = req.task_priority;
        if (req.mode == MODE_INIT) begin
          due_of[req.task_id] = req.now_tick;
        end
        if (req.mode == MODE_MANUAL) begin
          due_of[req.task_id] = due_of[req.task_id] + req.task_period;
        end
        key = (req.mode == MODE_MANUAL) ? due_of[req.task_id] : req.now_tick;
        if (list_ids.size() >= MAX_TASKS) begin
          res.list_full_error = 1'b1;
        end else if (req.mode == MODE_CANNOT) begin
          list_ids.push_front(req.task_id);
        end else begin
          slot = 0;
          while (slot < list_ids.size() &&
                 !(due_of[list_ids[slot]] > key ||
                   (due_of[list_ids[slot]] == key &&
                    prio_of[list_ids[slot]] > req.task_priority))) begin
            slot++;
          end
          if (slot == list_ids.size()) begin
            list_ids.push_back(req.task_id);
          end else begin
            list_ids.insert(slot, req.task_id);
          end
        end
      end
      default: begin
      end
    endcase
    res.queued_count = QCOUNT_W'(list_ids.size());
    return res;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(100, 600);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (request_valid && !request_stall) begin
        req_taken = 1'b1;
        want_res = requeue_and_dispatch(request);
        expected_results.push_back(want_res);
        n_accepted++;
        if (request.mode == MODE_DISPATCH) begin
          n_checks++;
        end else if (request.mode <= MODE_MANUAL) begin
          n_inserts++;
        end else begin
          n_spare++;
        end
        if (want_res.dispatched) n_popped++;
        if (want_res.list_full_error) n_rejected++;
        if (list_ids.size() > deepest) deepest = list_ids.size();
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          flag_error("result beat arrived with no request waiting for it");
        end else begin
          want_res = expected_results.pop_front();
          if (result.dispatched !== want_res.dispatched)
            flag_error($sformatf("dispatched: got %0b, expected %0b",
                                 result.dispatched, want_res.dispatched));
          if (result.dispatched_id !== want_res.dispatched_id)
            flag_error($sformatf("dispatched_id: got %0d, expected %0d",
                                 result.dispatched_id, want_res.dispatched_id));
          if (result.list_full_error !== want_res.list_full_error)
            flag_error($sformatf("list_full_error: got %0b, expected %0b",
                                 result.list_full_error, want_res.list_full_error));
          if (result.queued_count !== want_res.queued_count)
            flag_error($sformatf("queued_count: got %0d, expected %0d",
                                 result.queued_count, want_res.queued_count));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!request_valid || req_taken) begin
        if (send_gap > 0) begin
          request_valid <= 1'b0;
          send_gap--;
        end else if (beat_queue.size() > 0) begin
          request <= beat_queue.pop_front();
          request_valid <= 1'b1;
          send_gap = calm ? 0 : idle_length();
        end else begin
          request_valid <= 1'b0;
        end
      end
      if (recv_hold > 0) begin
        result_stall <= 1'b1;
        recv_hold--;
      end else begin
        result_stall <= 1'b0;
        if (!calm && $urandom_range(0, 2) == 0) recv_hold = idle_length();
      end
    end
  end

  task automatic queue_beat(input logic [MODE_W-1:0] mode, input id_t id, input prio_t prio,
                            input logic [PERIOD_W-1:0] period, input tick_t now);
    request_t beat;
    beat.mode = mode;
    beat.task_id = id;
    beat.task_priority = prio;
    beat.task_period = period;
    beat.now_tick = now;
    beat_queue.push_back(beat);
    if (mode == MODE_INIT) due_written[id] = 1'b1;
  endtask

  task automatic wait_until_idle();
    while (beat_queue.size() != 0 || request_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic prio_t pick_prio();
    if ($urandom_range(0, 1) == 0) return prio_t'($urandom_range(0, 3));
    return prio_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 30);
    if (roll < 90) return $urandom_range(0, 5000);
    return $urandom;
  endfunction

  function automatic id_t pick_known_id();
    id_t id;
    do begin
      id = id_t'($urandom_range(0, ID_SLOTS - 1));
    end while (!due_written[id]);
    return id;
  endfunction

  task automatic queue_random_insert();
    int unsigned roll;
    int unsigned pick;
    tick_t now;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    sim_now += $urandom_range(0, 3);
    if (pick < 80) now = sim_now;
    else if (pick < 90) now = sim_now - $urandom_range(0, 100);
    else if (pick < 96) now = {$urandom, $urandom};
    else now = (pick[0]) ? TICK_MAX : '0;
    if (roll < 45) begin
      queue_beat(MODE_INIT, id_t'($urandom_range(0, ID_SLOTS - 1)), pick_prio(),
                 pick_period(), now);
    end else if (roll < 65) begin
      queue_beat(MODE_MANUAL, pick_known_id(), pick_prio(), pick_period(), now);
    end else if (roll < 82) begin
      queue_beat(MODE_SYSTEM, pick_known_id(), pick_prio(), pick_period(), now);
    end else begin
      queue_beat(MODE_CANNOT, pick_known_id(), pick_prio(), pick_period(), now);
    end
  endtask

  task automatic queue_random_dispatch();
    int unsigned pick;
    tick_t now;
    pick = $urandom_range(0, 99);
    sim_now += $urandom_range(0, 3);
    if (pick < 55) now = sim_now + $urandom_range(0, 60);
    else if (pick < 75) now = TICK_MAX;
    else if (pick < 85) now = sim_now - $urandom_range(0, 200);
    else now = {$urandom, $urandom};
    queue_beat(MODE_DISPATCH, id_t'($urandom_range(0, ID_SLOTS - 1)), prio_t'($urandom),
               $urandom, now);
  endtask

  task automatic queue_spare_mode();
    logic [MODE_W-1:0] mode;
    case ($urandom_range(0, 2))
      0: mode = MODE_SPARE_A;
      1: mode = MODE_SPARE_B;
      default: mode = MODE_SPARE_C;
    endcase
    queue_beat(mode, id_t'($urandom_range(0, ID_SLOTS - 1)), prio_t'($urandom), $urandom,
               {$urandom, $urandom});
  endtask

  initial begin
    int unsigned produced;
    int unsigned since_pause;
    int unsigned span;
    int unsigned roll;
    int unsigned kind;

    sim_now = tick_t'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_beat(MODE_DISPATCH, '0, '0, '0, '0);
    queue_beat(MODE_SPARE_A, '1, '1, '1, TICK_MAX);
    queue_beat(MODE_SPARE_C, '0, '0, '0, '0);
    queue_beat(MODE_INIT, 4'd0, 8'hFF, '0, '0);
    queue_beat(MODE_INIT, 4'd15, 8'h00, '1, '0);
    queue_beat(MODE_INIT, 4'd3, 8'h00, '0, '0);
    queue_beat(MODE_MANUAL, 4'd15, 8'h80, '1, '0);
    queue_beat(MODE_INIT, 4'd7, 8'h01, '0, TICK_MAX - 15);
    queue_beat(MODE_MANUAL, 4'd7, 8'h01, 32'h20, '0);
    queue_beat(MODE_CANNOT, 4'd3, 8'h09, '0, '0);
    queue_beat(MODE_SYSTEM, 4'd0, 8'h05, '0, 64'd5);
    queue_beat(MODE_DISPATCH, '0, '0, '0, '0);
    queue_beat(MODE_DISPATCH, '0, '0, '0, TICK_MAX);
    for (int k = 4; k < 14; k++) begin
      queue_beat(MODE_INIT, id_t'(k), pick_prio(), '0, sim_now);
    end
    queue_beat(MODE_INIT, 4'd14, 8'h10, '0, sim_now);
    queue_beat(MODE_MANUAL, 4'd7, 8'h20, 32'h1234, '0);
    queue_beat(MODE_CANNOT, 4'd0, 8'h30, '0, '0);
    wait_until_idle();

    produced = 0;
    since_pause = 0;
    while (produced < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        span = $urandom_range(6, 20);
        kind = 0;
      end else if (roll < 60) begin
        span = $urandom_range(4, 18);
        kind = 1;
      end else begin
        span = $urandom_range(10, 30);
        kind = 2;
      end
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (kind == 0 || (kind == 2 && roll >= 45 && roll < 95)) begin
          queue_random_insert();
        end else if (kind == 1 || roll < 45) begin
          queue_random_dispatch();
        end else begin
          queue_spare_mode();
        end
      end
      produced += span;
      since_pause += span;
      while (beat_queue.size() > 8) @(posedge clk);
      if (since_pause > 400) begin
        wait_until_idle();
        since_pause = 0;
      end
    end

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Covered %0d requests: %0d dispatch checks, %0d inserts, %0d spare modes.",
             n_accepted, n_checks, n_inserts, n_spare);
    $display("%0d tasks dispatched, %0d inserts rejected on a full list, deepest list %0d.",
             n_popped, n_rejected, deepest);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
